>>> hdl/rokl_pkg.sv
// Shared types and constants for the recency-ordered key list.
package rokl_pkg;

  localparam int KEY_W           = 64;
  localparam int POS_W           = 4;
  localparam int CNT_W           = 5;
  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_KEY_BITS    = 64;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  read_key;
    logic [CNT_W-1:0]  entry_count;
  } out_word_t;

  // per-cell control from the list controller
  typedef struct packed {
    logic live;   // cell holds a key
    logic shift;  // take the key of the next newer cell
    logic load;   // take the appended key
  } cell_ctl_t;

endpackage

>>> hdl/rokl_cell.sv
// One storage cell of the key list: holds a key, compares it, shifts or loads.
module rokl_cell
  import rokl_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] cmp_key,
  input  logic [KEY_BITS-1:0] upper_key,
  input  logic [KEY_BITS-1:0] load_key,
  input  logic                seen_in,
  output logic [KEY_BITS-1:0] key_q,
  output logic                match,
  output logic                seen_out
);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;

  assign match    = ctl.live && (key_r == cmp_key);
  // set in this cell and every newer one once a match was found below
  assign seen_out = seen_in | match;
  assign key_q    = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = load_key;
    end else if (ctl.shift) begin
      key_nxt = upper_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

>>> hdl/recency_ordered_key_list_top.sv
// Top level of the recency-ordered key list: controller, cell chain and result register.
//
// Usage
//   in_*  : request word (kind, key, position), valid/ready handshake.
//   out_* : result word (ok, read_key, entry_count), valid/ready handshake,
//           exactly one result word per request word.
//   cfg_* : cfg_we writes max_entries from cfg_data; write only while idle.
// Timing
//   A request is taken and fully applied by the cell chain in the cycle it is
//   accepted; its result appears in the output register on the next cycle.
//   Throughput is one word per cycle while the receiver keeps out_ready high
//   and no trim runs. Lowering max_entries below the held count starts a trim:
//   the chain drops the oldest key once per cycle, and in_ready stays low until
//   the held count is down to the new limit.
// Reset
//   rst_n (synchronous) empties the list, sets max_entries to 16 and clears
//   the output valid flag. Key cells are not reset; only live cells are used.
// Backpressure
//   When out_ready is low the result holds and in_ready drops until the
//   result is taken, so no word is lost or repeated.
module recency_ordered_key_list_top
  import rokl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  // state
  logic [CW-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0] max_entries_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  // cell chain
  logic [KEY_BITS-1:0] key_q [CAPACITY];
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] seen_v;
  cell_ctl_t           ctl_v [CAPACITY];

  // control
  logic [CMPW-1:0]     cnt_w, lim_w, pos_w, tail_w, newcnt_w;
  logic [KEY_BITS-1:0] cmp_key, sel_key, load_key;
  logic                trim, fire, pos_ok, any_match, ok;
  logic                sh_all, sh_seen, sh_pos, do_load;
  out_word_t           res_word;

  assign cnt_w     = CMPW'(count_r);
  assign pos_w     = CMPW'(in_word.position);
  assign cmp_key   = in_word.key[KEY_BITS-1:0];
  assign any_match = |match_v;
  assign pos_ok    = pos_w < cnt_w;

  // effective limit: max_entries clamped to 1..CAPACITY
  always_comb begin
    lim_w = CMPW'(max_entries_r);
    if (lim_w == '0) begin
      lim_w = CMPW'(1);
    end
    if (lim_w > CMPW'(CAPACITY)) begin
      lim_w = CMPW'(CAPACITY);
    end
  end

  assign trim     = cnt_w > lim_w;
  assign in_ready = !trim && (!out_valid_r || out_ready);
  assign fire     = in_valid && in_ready;

  // key at the requested position
  always_comb begin
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key = sel_key | (key_q[i] & {KEY_BITS{pos_w == CMPW'(i)}});
    end
  end

  // every request drops at most one entry, then optionally appends at tail
  always_comb begin
    sh_all   = 1'b0;
    sh_seen  = 1'b0;
    sh_pos   = 1'b0;
    do_load  = 1'b0;
    ok       = 1'b0;
    load_key = cmp_key;
    tail_w   = cnt_w;
    newcnt_w = cnt_w;
    if (trim) begin
      sh_all   = 1'b1;
      newcnt_w = cnt_w - CMPW'(1);
    end else if (fire) begin
      unique case (in_word.kind)
        KIND_ADD: begin
          ok      = 1'b1;
          do_load = 1'b1;
          if (any_match) begin
            sh_seen = 1'b1;
            tail_w  = cnt_w - CMPW'(1);
          end else if (cnt_w >= lim_w) begin
            sh_all  = 1'b1;
            tail_w  = cnt_w - CMPW'(1);
          end else begin
            newcnt_w = cnt_w + CMPW'(1);
          end
        end
        KIND_MOVE: begin
          if (pos_ok) begin
            ok       = 1'b1;
            sh_pos   = 1'b1;
            do_load  = 1'b1;
            load_key = sel_key;
            tail_w   = cnt_w - CMPW'(1);
          end
        end
        KIND_REMOVE: begin
          if (pos_ok) begin
            ok       = 1'b1;
            sh_pos   = 1'b1;
            newcnt_w = cnt_w - CMPW'(1);
          end
        end
        KIND_READ: begin
          ok = pos_ok;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl_v[i].live  = CMPW'(i) < cnt_w;
      ctl_v[i].shift = sh_all || (sh_seen && seen_v[i]) || (sh_pos && (CMPW'(i) >= pos_w));
      ctl_v[i].load  = do_load && (tail_w == CMPW'(i));
    end
  end

  assign count_nxt = CW'(newcnt_w);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
    logic [KEY_BITS-1:0] upper;
    logic                seen_below;
    if (g == CAPACITY - 1) begin : g_last
      assign upper = key_q[g];
    end else begin : g_mid
      assign upper = key_q[g+1];
    end
    if (g == 0) begin : g_first
      assign seen_below = 1'b0;
    end else begin : g_rest
      assign seen_below = seen_v[g-1];
    end
    rokl_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl_v[g]),
      .cmp_key   (cmp_key),
      .upper_key (upper),
      .load_key  (load_key),
      .seen_in   (seen_below),
      .key_q     (key_q[g]),
      .match     (match_v[g]),
      .seen_out  (seen_v[g])
    );
  end

  always_comb begin
    res_word.ok          = ok;
    res_word.read_key    = (in_word.kind == KIND_READ && pos_ok) ? KEY_W'(sel_key) : '0;
    res_word.entry_count = CNT_W'(newcnt_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        max_entries_r <= cfg_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // held keys stay distinct
  a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("more than one live cell matches the key");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= CMPW'(CAPACITY))
    else $error("held count above capacity");

  a_trim_step: assert property (@(posedge clk) disable iff (!rst_n)
    trim && !cfg_we |=> count_r == CW'($past(count_r) - CW'(1)))
    else $error("trim did not drop exactly one entry");

  a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_word.kind == KIND_READ |=> count_r == $past(count_r))
    else $error("read changed the held count");

  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_word.kind == KIND_ADD |=> out_valid_r && out_word_r.ok && count_r != '0)
    else $error("add left the list empty");

endmodule

>>> tb/sv/recency_ordered_key_list_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the recency-ordered key list top level.
module recency_ordered_key_list_top_test;
  import rokl_pkg::*;

  localparam int CLK_HI       = 4;
  localparam int CLK_LO       = 4;
  localparam int RESET_CYCLES = 12;
  // cycles with no word moving on either channel before the run is called hung;
  // well above the long receiver hold plus a full trim
  localparam int STALL_LIMIT  = 2000;
  // quiet cycles after the last result: covers a trim and the output register
  localparam int SETTLE       = 24;
  localparam int LONG_HOLD    = 300;
  localparam int POOL_N       = 24;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - DEF_KEY_BITS);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  recency_ordered_key_list_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #(CLK_LO) clk = 1'b1;
    #(CLK_HI) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list: oldest key at index 0, newest at mru_len-1.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] mru_keys [DEF_CAPACITY];
  int unsigned      mru_len = 0;
  logic [CNT_W-1:0] limit_reg = MAX_ENTRIES_RST;

  // register value clamped to 1..CAPACITY (0 acts as 1, 17..31 act as 16)
  function automatic int unsigned live_limit();
    int unsigned m;
    m = 32'(limit_reg);
    if (m < 1) m = 1;
    if (m > DEF_CAPACITY) m = DEF_CAPACITY;
    return m;
  endfunction

  // close the gap at idx by shifting newer keys down
  function automatic void drop_entry(int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < mru_len; i++) mru_keys[i] = mru_keys[i + 1];
    mru_len--;
  endfunction

  function automatic void trim_to_limit();
    while (mru_len > live_limit()) drop_entry(0);
  endfunction

  function automatic void append_key(logic [KEY_W-1:0] k);
    if (mru_len < DEF_CAPACITY) begin
      mru_keys[mru_len] = k;
      mru_len++;
    end
  endfunction

  // a lowered limit drops the oldest surplus keys at once
  function automatic void limit_write(logic [CNT_W-1:0] v);
    limit_reg = v;
    trim_to_limit();
  endfunction

  // apply one request word to the shadow list, return the result word it yields
  function automatic out_word_t mru_apply(in_word_t w);
    out_word_t        r;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] t;
    int unsigned      p;
    int unsigned      i;
    bit               hit;
    r = '0;
    k = w.key & KEY_MASK;
    p = 32'(w.position);
    hit = 1'b0;
    trim_to_limit();
    case (w.kind)
      KIND_ADD: begin
        // a key already held moves to the top instead of being duplicated
        for (i = 0; i < mru_len && !hit; i++) begin
          if (mru_keys[i] == k) begin
            drop_entry(i);
            hit = 1'b1;
          end
        end
        if (mru_len >= live_limit()) drop_entry(0);
        append_key(k);
        r.ok = 1'b1;
      end
      KIND_MOVE: begin
        if (p < mru_len) begin
          t = mru_keys[p];
          drop_entry(p);
          append_key(t);
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (p < mru_len) begin
          drop_entry(p);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (p < mru_len) begin
          r.read_key = mru_keys[p];
          r.ok = 1'b1;
        end
      end
    endcase
    r.entry_count = mru_len[CNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and pacing knobs shared by the processes.
  // pending_words: request words not yet accepted (filled by the sequence below)
  // result_q:      result words predicted at acceptance, oldest first
  // ---------------------------------------------------------------------------
  in_word_t  pending_words [$];
  out_word_t result_q [$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  int        errors = 0;
  int        quiet_cycles = 0;

  // Driver: offers the head of pending_words, holds it until taken.
  // Prediction happens here, at the edge the word is accepted.
  always @(posedge clk) begin : drive
    bit taken;
    taken = in_valid && in_ready;
    if (taken) begin
      result_q.push_back(mru_apply(in_word));
      pending_words.delete(0);
    end
    if (in_valid && !taken) begin
      // word still waiting: keep valid and payload steady
    end else if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_word  <= pending_words[0];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Monitor: checks each taken result word against the oldest prediction,
  // then picks out_ready for the next cycle. A long hold counts down here.
  always @(posedge clk) begin : watch
    out_word_t want;
    if (out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("result word with nothing expected: ok=%0d read_key=%h entry_count=%0d",
               out_word.ok, out_word.read_key, out_word.entry_count);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_word.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_word.ok);
          errors++;
        end
        if (out_word.read_key !== want.read_key) begin
          $error("read_key: expected %h, got %h", want.read_key, out_word.read_key);
          errors++;
        end
        if (out_word.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_word.entry_count);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any cycle that moves a word restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers. All run from negedge so they never race the edge logic.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool [POOL_N];

  task automatic queue_word(kind_t kd, logic [KEY_W-1:0] k, logic [POS_W-1:0] p);
    in_word_t w;
    w.kind = kd;
    w.key = k;
    w.position = p;
    pending_words.push_back(w);
  endtask

  // wait until every word is taken and every result checked, then let a trim finish
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() > 0 || result_q.size() > 0 || in_valid) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_limit(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    limit_write(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // random request: mostly keys from a small pool so duplicates are common,
  // positions split between the whole range and the range below the limit
  task automatic queue_random(int n, int lim);
    int               roll;
    kind_t            kd;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] p;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) kd = KIND_ADD;
      else if (roll < 65) kd = KIND_MOVE;
      else if (roll < 80) kd = KIND_REMOVE;
      else kd = KIND_READ;
      if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, POOL_N - 1)];
      else k = {$urandom, $urandom};
      if ($urandom_range(0, 1)) p = POS_W'($urandom_range(0, 15));
      else p = POS_W'($urandom_range(0, lim - 1));
      queue_word(kd, k, p);
    end
  endtask

  task automatic random_phase(logic [CNT_W-1:0] lim_val, int s_pct, int r_pct, int n,
                              bit long_hold);
    int lim;
    lim = (lim_val < 1) ? 1 : (lim_val > DEF_CAPACITY) ? DEF_CAPACITY : 32'(lim_val);
    write_limit(lim_val);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    // receiver backs off while the sender keeps pushing: result register and
    // input side both fill and stall
    if (long_hold) hold_left = LONG_HOLD;
    queue_random(n, lim);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int i;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset limit of 16: empty-list misses, extreme keys, duplicate add,
    // positions just inside and outside the live range.
    queue_word(KIND_READ,   '0, 4'd0);
    queue_word(KIND_MOVE,   '0, 4'd15);
    queue_word(KIND_REMOVE, '1, 4'd0);
    queue_word(KIND_ADD,    '0, 4'd0);
    queue_word(KIND_ADD,    '1, 4'd15);
    queue_word(KIND_ADD,    {16{4'h5}}, 4'd0);
    queue_word(KIND_ADD,    {16{4'hA}}, 4'd0);
    queue_word(KIND_ADD,    '0, 4'd0);        // already held: goes to the top
    queue_word(KIND_READ,   '0, 4'd0);
    queue_word(KIND_READ,   '0, 4'd3);
    queue_word(KIND_READ,   '0, 4'd4);        // one past the newest
    queue_word(KIND_MOVE,   '0, 4'd0);
    queue_word(KIND_REMOVE, '0, 4'd1);
    queue_word(KIND_READ,   '0, 4'd15);
    queue_word(KIND_READ,   '0, 4'd2);
    drain();

    // Directed, limit 0 acts as 1: trim on write, an add to the full list evicts.
    write_limit(5'd0);
    queue_word(KIND_ADD,    {32'h0123_4567, 32'h89AB_CDEF}, 4'd0);
    queue_word(KIND_ADD,    {32'hFEDC_BA98, 32'h7654_3210}, 4'd0);
    queue_word(KIND_READ,   '0, 4'd0);
    queue_word(KIND_MOVE,   '0, 4'd0);
    queue_word(KIND_REMOVE, '0, 4'd0);
    queue_word(KIND_READ,   '0, 4'd0);
    queue_word(KIND_ADD,    '1, 4'd1);
    queue_word(KIND_MOVE,   '0, 4'd1);
    drain();

    // Random phases: limits swing between extremes so lowering hits a full list.
    random_phase(5'd31, 0,  0,  200, 1'b0);
    random_phase(5'd16, 64, 0,  190, 1'b0);
    random_phase(5'd3,  0,  64, 170, 1'b0);
    random_phase(5'd17, 15, 15, 170, 1'b1);
    random_phase(5'd1,  0,  0,  110, 1'b0);
    random_phase(5'd8,  64, 0,  160, 1'b0);
    random_phase(5'd16, 0,  64, 190, 1'b0);
    random_phase(5'd2,  15, 15, 140, 1'b0);
    random_phase(5'd16, 0,  0,  100, 1'b1);

    if (errors == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
